// ===== rtl/rpn_stk_pkg.sv =====
package rpn_stk_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 16;

  localparam int unsigned MODE_W      = 4;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned DEPTH_NOW_W = 5;
  localparam int unsigned S_TDATA_W   = 72;
  localparam int unsigned M_TDATA_W   = 144;

  localparam logic [KIND_W-1:0] KIND_NIL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNDEF = 3'd7;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENTER_VAL = 4'd0,
    MODE_POP       = 4'd1,
    MODE_ROLL_DOWN = 4'd2,
    MODE_ROLL_UP   = 4'd3,
    MODE_SWAP_XY   = 4'd4,
    MODE_SWAP_XZ   = 4'd5,
    MODE_SWAP_XT   = 4'd6,
    MODE_SWAP_XL   = 4'd7,
    MODE_ENTER     = 4'd8,
    MODE_CLX       = 4'd9,
    MODE_DELX      = 4'd10,
    MODE_CLST      = 4'd11,
    MODE_LASTX     = 4'd12,
    MODE_RCLX      = 4'd13,
    MODE_SET_LASTX = 4'd14
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EXEC  = 3'd1,
    ST_EXEC2 = 3'd2,
    ST_FETCH = 3'd3,
    ST_DONE  = 3'd4
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
  } slot_t;

  localparam slot_t SLOT_NIL  = '{kind: KIND_NIL, word: 64'd0};
  localparam slot_t SLOT_INT0 = '{kind: KIND_INT, word: 64'd0};

  typedef struct packed {
    logic capture;
    logic exec;
    logic exec2;
    logic fetch;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic two_writes;
  } dp_status_t;

  typedef struct packed {
    logic                   overflow;
    logic [DEPTH_NOW_W-1:0] depth_now;
    logic [KIND_W-1:0]      second_kind;
    logic [WORD_W-1:0]      top_word;
    logic [KIND_W-1:0]      top_kind;
    logic [WORD_W-1:0]      taken_word;
    logic [KIND_W-1:0]      taken_kind;
  } result_t;

endpackage

// ===== rtl/rpn_stk_ctrl.sv =====
module rpn_stk_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  output logic                    s_ready_o,
  input  logic                    m_ready_i,
  output logic                    m_valid_o,
  input  rpn_stk_pkg::dp_status_t status_i,
  output rpn_stk_pkg::ctrl_cmd_t  cmd_o
);

  rpn_stk_pkg::state_e state_q, state_d;
  logic                m_valid_q, m_valid_d;
  logic                out_free;

  assign out_free  = !m_valid_q || m_ready_i;
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpn_stk_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = rpn_stk_pkg::ST_EXEC;
      end
      rpn_stk_pkg::ST_EXEC: begin
        state_d = status_i.two_writes ? rpn_stk_pkg::ST_EXEC2 : rpn_stk_pkg::ST_FETCH;
      end
      rpn_stk_pkg::ST_EXEC2: state_d = rpn_stk_pkg::ST_FETCH;
      rpn_stk_pkg::ST_FETCH: state_d = rpn_stk_pkg::ST_DONE;
      rpn_stk_pkg::ST_DONE: begin
        // hold until the output register can take the result
        if (out_free) state_d = rpn_stk_pkg::ST_IDLE;
      end
      default: state_d = rpn_stk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o     = (state_q == rpn_stk_pkg::ST_IDLE);
    cmd_o.capture = (state_q == rpn_stk_pkg::ST_IDLE) && s_valid_i;
    cmd_o.exec    = (state_q == rpn_stk_pkg::ST_EXEC);
    cmd_o.exec2   = (state_q == rpn_stk_pkg::ST_EXEC2);
    cmd_o.fetch   = (state_q == rpn_stk_pkg::ST_FETCH);
    cmd_o.load    = (state_q == rpn_stk_pkg::ST_DONE) && out_free;
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rpn_stk_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == rpn_stk_pkg::ST_EXEC)
    else $error("command beat not followed by execute");

  a_exec2_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rpn_stk_pkg::ST_EXEC2 |-> $past(state_q) == rpn_stk_pkg::ST_EXEC)
    else $error("second write without first write");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rpn_stk_pkg::ST_DONE && !out_free |=> state_q == rpn_stk_pkg::ST_DONE &&
    m_valid_q)
    else $error("result dropped while output stalled");

endmodule

// ===== rtl/rpn_stk_dp.sv =====
module rpn_stk_dp #(
  parameter int unsigned STACK_DEPTH = rpn_stk_pkg::DEF_STACK_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rpn_stk_pkg::ctrl_cmd_t                cmd_i,
  output rpn_stk_pkg::dp_status_t               status_o,
  input  logic [rpn_stk_pkg::MODE_W-1:0]        in_mode_i,
  input  logic [rpn_stk_pkg::KIND_W-1:0]        in_kind_i,
  input  logic [rpn_stk_pkg::WORD_W-1:0]        in_word_i,
  output rpn_stk_pkg::result_t                  res_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(STACK_DEPTH);

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, off};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] cnt2off(input logic [CW-1:0] c);
    logic [CW+AW-1:0] e;
    e = {{AW{1'b0}}, c};
    return e[AW-1:0];
  endfunction

  function automatic logic [1:0] swap_dist(input rpn_stk_pkg::mode_e m);
    logic [1:0] k;
    unique case (m)
      rpn_stk_pkg::MODE_SWAP_XY: k = 2'd1;
      rpn_stk_pkg::MODE_SWAP_XZ: k = 2'd2;
      rpn_stk_pkg::MODE_SWAP_XT: k = 2'd3;
      default:                   k = 2'd0;
    endcase
    return k;
  endfunction

  rpn_stk_pkg::slot_t slot_mem [STACK_DEPTH];

  logic [CW-1:0]       n_q, n_d;
  logic [AW-1:0]       b_q, b_d;
  logic                cp_q, cp_d;
  rpn_stk_pkg::slot_t  last_q, last_d;
  rpn_stk_pkg::mode_e  mode_q;
  rpn_stk_pkg::slot_t  nslot_q;
  rpn_stk_pkg::slot_t  rd_a_q, rd_b_q;
  rpn_stk_pkg::slot_t  taken_q, taken_d;
  logic                drop_q, drop_d;
  rpn_stk_pkg::result_t res_q;

  logic                n_nz, n_full;
  logic [CW-1:0]       n_m1, n_e;
  rpn_stk_pkg::mode_e  in_mode;
  logic [1:0]          k_rd, k_ex;
  logic [AW-1:0]       off_a, off_b, raddr_a, raddr_b;
  logic                rd_en;
  logic                we;
  logic [AW-1:0]       woff, waddr, push_off;
  rpn_stk_pkg::slot_t  wdata;
  logic [CW+4:0]       n_ext;

  assign n_nz     = (n_q != '0);
  assign n_full   = (n_q == DEPTH_C);
  assign n_m1     = n_nz ? n_q - CW'(1) : '0;
  assign n_e      = cp_q ? n_m1 : n_q;
  assign push_off = n_full ? '0 : cnt2off(n_q);
  assign in_mode  = rpn_stk_pkg::mode_e'(in_mode_i);
  assign k_ex     = swap_dist(mode_q);

  // Capture reads X (or the base for roll up) and the swap partner;
  // fetch reads the new X and Y.
  assign k_rd  = cmd_i.capture ? swap_dist(in_mode) : 2'd1;
  assign off_a = (cmd_i.capture && in_mode == rpn_stk_pkg::MODE_ROLL_UP) ? '0 : cnt2off(n_m1);
  assign off_b = (n_q > CW'(k_rd)) ? cnt2off(n_m1 - CW'(k_rd)) : '0;
  assign raddr_a = ptr_add(b_q, off_a);
  assign raddr_b = ptr_add(b_q, off_b);
  assign rd_en   = cmd_i.capture || cmd_i.fetch;

  assign status_o.two_writes = (k_ex != 2'd0) && (n_q > CW'(k_ex));

  always_comb begin
    we      = 1'b0;
    woff    = push_off;
    wdata   = nslot_q;
    n_d     = n_q;
    b_d     = b_q;
    cp_d    = cp_q;
    last_d  = last_q;
    taken_d = taken_q;
    drop_d  = drop_q;
    if (cmd_i.exec) begin
      cp_d    = 1'b0;
      taken_d = rpn_stk_pkg::SLOT_NIL;
      drop_d  = 1'b0;
      unique case (mode_q)
        rpn_stk_pkg::MODE_ENTER_VAL: begin
          // armed clear-X replaces X
          if (n_e == DEPTH_C) begin
            drop_d = 1'b1;
          end else begin
            we    = 1'b1;
            woff  = cnt2off(n_e);
            wdata = nslot_q;
            n_d   = n_e + CW'(1);
          end
        end
        rpn_stk_pkg::MODE_POP: begin
          if (n_nz) begin
            taken_d = rd_a_q;
            n_d     = n_m1;
          end
        end
        rpn_stk_pkg::MODE_ROLL_DOWN: begin
          we   = 1'b1;
          woff = AW'(STACK_DEPTH - 1);
          b_d  = ptr_add(b_q, AW'(STACK_DEPTH - 1));
          if (n_nz) begin
            wdata = rd_a_q;
          end else begin
            wdata = rpn_stk_pkg::SLOT_NIL;
            n_d   = CW'(1);
          end
        end
        rpn_stk_pkg::MODE_ROLL_UP: begin
          we   = 1'b1;
          woff = push_off;
          if (n_nz) begin
            wdata = rd_a_q;
            b_d   = ptr_add(b_q, AW'(1));
          end else begin
            wdata = rpn_stk_pkg::SLOT_INT0;
            n_d   = CW'(1);
          end
        end
        rpn_stk_pkg::MODE_SWAP_XY,
        rpn_stk_pkg::MODE_SWAP_XZ,
        rpn_stk_pkg::MODE_SWAP_XT: begin
          if (n_q > CW'(k_ex)) begin
            we    = 1'b1;
            woff  = cnt2off(n_m1);
            wdata = rd_b_q;
          end
        end
        rpn_stk_pkg::MODE_SWAP_XL: begin
          if (n_nz) begin
            we     = 1'b1;
            woff   = cnt2off(n_m1);
            wdata  = last_q;
            last_d = rd_a_q;
          end
        end
        rpn_stk_pkg::MODE_ENTER,
        rpn_stk_pkg::MODE_RCLX: begin
          if (n_nz) begin
            if (n_full) begin
              drop_d = 1'b1;
            end else begin
              we    = 1'b1;
              woff  = push_off;
              wdata = rd_a_q;
              n_d   = n_q + CW'(1);
            end
          end
          cp_d = (mode_q == rpn_stk_pkg::MODE_ENTER);
        end
        rpn_stk_pkg::MODE_CLX: begin
          we    = 1'b1;
          woff  = cnt2off(n_m1);
          wdata = rpn_stk_pkg::SLOT_NIL;
          n_d   = n_m1 + CW'(1);
          cp_d  = 1'b1;
        end
        rpn_stk_pkg::MODE_DELX: begin
          n_d = n_m1;
        end
        rpn_stk_pkg::MODE_CLST: begin
          we    = 1'b1;
          woff  = '0;
          wdata = rpn_stk_pkg::SLOT_NIL;
          n_d   = CW'(1);
          cp_d  = 1'b1;
        end
        rpn_stk_pkg::MODE_LASTX: begin
          if (n_nz) begin
            if (n_full) begin
              drop_d = 1'b1;
            end else begin
              we    = 1'b1;
              woff  = push_off;
              wdata = last_q;
              n_d   = n_q + CW'(1);
            end
          end
        end
        rpn_stk_pkg::MODE_SET_LASTX: begin
          last_d = nslot_q;
        end
        default: ;
      endcase
    end else if (cmd_i.exec2) begin
      // old X goes to the partner slot
      we    = 1'b1;
      woff  = cnt2off(n_m1 - CW'(k_ex));
      wdata = rd_a_q;
    end
  end

  assign waddr = ptr_add(b_q, woff);

  always_ff @(posedge clk_i) begin
    if (we) slot_mem[waddr] <= wdata;
    if (rd_en) begin
      rd_a_q <= slot_mem[raddr_a];
      rd_b_q <= slot_mem[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      b_q    <= '0;
      cp_q   <= 1'b0;
      last_q <= rpn_stk_pkg::SLOT_INT0;
    end else begin
      n_q    <= n_d;
      b_q    <= b_d;
      cp_q   <= cp_d;
      last_q <= last_d;
    end
  end

  assign n_ext = {5'b0, n_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q       <= in_mode;
      nslot_q.kind <= in_kind_i;
      nslot_q.word <= in_word_i;
    end
    taken_q <= taken_d;
    drop_q  <= drop_d;
    if (cmd_i.load) begin
      res_q.taken_kind  <= taken_q.kind;
      res_q.taken_word  <= taken_q.word;
      res_q.top_kind    <= n_nz ? rd_a_q.kind : rpn_stk_pkg::KIND_UNDEF;
      res_q.top_word    <= n_nz ? rd_a_q.word : '0;
      res_q.second_kind <= (n_q > CW'(1)) ? rd_b_q.kind : rpn_stk_pkg::KIND_NIL;
      res_q.depth_now   <= n_ext[4:0];
      res_q.overflow    <= drop_q;
    end
  end

  assign res_o = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= DEPTH_C)
    else $error("element count above stack depth");

  a_exec2_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec2 |-> $past(cmd_i.exec) && $past(status_o.two_writes))
    else $error("second write outside a swap");

endmodule

// ===== rtl/rpn_operand_stack_engine_core.sv =====
// Calculator operand stack: a circular deque of typed 64-bit words with
// a last-X register and a clear-X flag.
// Command channel (s_axis): one beat carries mode, new_kind and new_word.
// Result channel (m_axis): one beat per command with the popped element,
// the new X, the kind of Y, the element count and the overflow flag.
// Sequence: a beat is taken in idle; execute, fetch and done follow,
// done loads the result, and the next command is taken back in idle.
// Swap X/Y, X/Z and X/T add a second execute state when the partner is
// held, as each needs two writes through the slot memory's single write port.
// The slot memory has one write and two registered read ports: the
// command cycle reads X and its partner, a fetch cycle reads the new X, Y.
// Reset empties the stack, clears clear-X and sets last-X to INT 0; slot
// contents are not cleared and only held entries are ever read.
// A stalled result stays in the output register; a finished command waits
// for it to be taken, and s_axis_tready stays low meanwhile.
module rpn_operand_stack_engine_core #(
  parameter int unsigned STACK_DEPTH = rpn_stk_pkg::DEF_STACK_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [3:0] mode, [6:4] new_kind, [70:7] new_word, [71] zero
  input  logic [rpn_stk_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] taken_kind, [66:3] taken_word, [69:67] top_kind,
  // [133:70] top_word, [136:134] second_kind, [141:137] depth_now,
  // [142] overflow, [143] zero
  output logic [rpn_stk_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  rpn_stk_pkg::ctrl_cmd_t  cmd;
  rpn_stk_pkg::dp_status_t status;
  rpn_stk_pkg::result_t    res;

  rpn_stk_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rpn_stk_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_mode_i (s_axis_tdata[3:0]),
    .in_kind_i (s_axis_tdata[6:4]),
    .in_word_i (s_axis_tdata[70:7]),
    .res_o     (res)
  );

  assign m_axis_tdata = {1'b0, res.overflow, res.depth_now, res.second_kind, res.top_word,
                         res.top_kind, res.taken_word, res.taken_kind};

endmodule
